>>> design/hrfw_pkg.sv
// hrfw_pkg: shared types, constants and the hex digit decoder for the
// hex record to flash word converter; depends on nothing
`default_nettype none

package hrfw_pkg;

  // character and record codes
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] REC_DATA     = 8'h00;
  localparam logic [7:0] REC_EXT_LIN  = 8'h04;

  // position bookkeeping inside a record
  localparam int unsigned POS_W       = 10;
  localparam logic [POS_W-1:0] POS_MAX    = 10'd1023;
  localparam logic [POS_W-1:0] POS_BC_END = 10'd2;
  localparam logic [POS_W-1:0] POS_OF_END = 10'd6;
  localparam logic [POS_W-1:0] POS_TY_END = 10'd8;
  localparam logic [POS_W-1:0] DATA_START = 10'd9;

  localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;

  // one result beat plus its valid flag
  typedef struct packed {
    logic        valid;
    logic [31:0] flash_address;
    logic [15:0] halfword;
    logic        last_of_record;
  } result_t;

  // uppercase hex digit decode, anything else reads as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c inside {[8'd48:8'd57]}) begin
        t = c - 8'd48;
      end else if (c inside {[8'd65:8'd70]}) begin
        t = c - 8'd55;
      end
      return t[3:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> design/hrfw_if.sv
// hrfw_in_if / hrfw_out_if: valid/ready channels for characters and
// flash words; no dependencies
`default_nettype none

interface hrfw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface hrfw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flash_address;
  logic [15:0] halfword;
  logic        last_of_record;
  modport source (output valid, output flash_address, output halfword,
                  output last_of_record, input ready);
  modport sink   (input valid, input flash_address, input halfword,
                  input last_of_record, output ready);
endinterface

`default_nettype wire

>>> design/hrfw_parser.sv
// hrfw_parser: record field state and per-character decode; produces at
// most one flash word per character; depends on hrfw_pkg
`default_nettype none

module hrfw_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          ch,
  input  wire logic [31:0]         flash_base,
  output hrfw_pkg::result_t        res
);

  logic [hrfw_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic        active_r, active_nxt;
  logic [7:0]  bc_r, bc_nxt;
  logic [15:0] off_r, off_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] upper_r, upper_nxt;
  logic        loaded_r, loaded_nxt;
  logic [11:0] nib_r, nib_nxt;

  logic [hrfw_pkg::POS_W-1:0] pos_inc, d;
  logic [3:0]  n;
  logic [1:0]  k;
  logic [7:0]  idx, words;
  logic [15:0] full;
  logic        is_colon, in_data, word_ok;
  logic [15:0] upper_sel, addr_lo;

  // shared decode of the current character
  always_comb begin
    is_colon  = (ch == hrfw_pkg::CHAR_COLON);
    pos_inc   = (pos_r < hrfw_pkg::POS_MAX) ? pos_r + 1'b1 : pos_r;
    n         = hrfw_pkg::hex_digit(ch);
    d         = pos_inc - hrfw_pkg::DATA_START;
    k         = d[1:0];
    idx       = d[9:2];
    words     = {1'b0, bc_r[7:1]};
    full      = {nib_r, n};
    in_data   = (pos_inc > hrfw_pkg::POS_TY_END);
    word_ok   = active_r && !is_colon && in_data && (k == 2'd3) && (idx < words);
    upper_sel = loaded_r ? upper_r : flash_base[31:16];
    addr_lo   = off_r + {7'd0, idx, 1'b0};
  end

  // next state
  always_comb begin
    pos_nxt    = pos_r;
    active_nxt = active_r;
    bc_nxt     = bc_r;
    off_nxt    = off_r;
    type_nxt   = type_r;
    upper_nxt  = upper_r;
    loaded_nxt = loaded_r;
    nib_nxt    = nib_r;
    if (is_colon) begin
      active_nxt = 1'b1;
      pos_nxt    = '0;
      bc_nxt     = '0;
      off_nxt    = '0;
      type_nxt   = '0;
      nib_nxt    = '0;
    end else if (active_r) begin
      pos_nxt = pos_inc;
      if (pos_inc <= hrfw_pkg::POS_BC_END) begin
        bc_nxt = {bc_r[3:0], n};
      end else if (pos_inc <= hrfw_pkg::POS_OF_END) begin
        off_nxt = {off_r[11:0], n};
      end else if (pos_inc <= hrfw_pkg::POS_TY_END) begin
        type_nxt = {type_r[3:0], n};
      end else begin
        case (k)
          2'd0: nib_nxt = {8'd0, n};
          2'd1,
          2'd2: nib_nxt = {nib_r[7:0], n};
          default: begin
            if (word_ok && (type_r == hrfw_pkg::REC_EXT_LIN) && (idx == 8'd0)) begin
              upper_nxt  = full;
              loaded_nxt = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // result word, bytes swapped so the first byte lands low
  always_comb begin
    res.valid          = word_ok && (type_r == hrfw_pkg::REC_DATA);
    res.flash_address  = {upper_sel, addr_lo};
    res.halfword       = {full[7:0], full[15:8]};
    res.last_of_record = ((idx + 8'd1) == words);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      bc_r     <= '0;
      off_r    <= '0;
      type_r   <= '0;
      upper_r  <= '0;
      loaded_r <= 1'b0;
      nib_r    <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      bc_r     <= bc_nxt;
      off_r    <= off_nxt;
      type_r   <= type_nxt;
      upper_r  <= upper_nxt;
      loaded_r <= loaded_nxt;
      nib_r    <= nib_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/hrfw_out_stage.sv
// hrfw_out_stage: result register driving the output channel
// depends on hrfw_pkg and hrfw_out_if
`default_nettype none

module hrfw_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire hrfw_pkg::result_t res,
  output logic               free,
  hrfw_out_if.source         out_chan
);

  logic        valid_r, valid_nxt;
  logic [31:0] addr_r;
  logic [15:0] hw_r;
  logic        last_r;

  // slot is free when empty or its beat leaves this cycle
  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= res.flash_address;
      hw_r   <= res.halfword;
      last_r <= res.last_of_record;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.flash_address  = addr_r;
  assign out_chan.halfword       = hw_r;
  assign out_chan.last_of_record = last_r;

endmodule

`default_nettype wire

>>> design/hex_record_to_flash_words_core.sv
// hex_record_to_flash_words_core: top level, input register, base register
// depends on hrfw_pkg, hrfw_if, hrfw_parser, hrfw_out_stage
`default_nettype none

// Takes one ASCII character per beat and returns little-endian flash
// halfwords from data records, each with its address. One character is
// accepted every clock cycle as long as the result side keeps taking words;
// a character passes an input register, then the record decode and the
// result register, which offers each completed word at the output. A word
// held by a stalled receiver holds the input register and with it new
// characters. The upper address half comes from cfg_wdata bits 31..16
// until an extended linear address record is seen. The user must write
// the base register with cfg_we only while no beat is in flight; the
// block does not enforce this.
module hex_record_to_flash_words_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  hrfw_in_if.sink          in_chan,
  hrfw_out_if.source       out_chan
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [7:0]        s1_ch_r;
  logic [31:0]       flash_base_r;
  logic              advance, out_free, in_fire;
  hrfw_pkg::result_t res;

  // base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= hrfw_pkg::FLASH_BASE_RST;
    end else if (cfg_we) begin
      flash_base_r <= cfg_wdata;
    end
  end

  // input register moves on unless its word finds the result slot full
  assign advance       = s1_valid_r && (!res.valid || out_free);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r <= in_chan.ch;
    end
  end

  hrfw_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .ch         (s1_ch_r),
    .flash_base (flash_base_r),
    .res        (res)
  );

  hrfw_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && res.valid),
    .res      (res),
    .free     (out_free),
    .out_chan (out_chan)
  );

  // a held word blocks new characters
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res.valid && !out_free) |-> !in_chan.ready)
    else $error("input taken while result slot blocked");

  // a new output beat only comes from a decoded word
  a_out_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !$past(out_chan.valid)) |-> $past(advance && res.valid))
    else $error("output beat without source word");

  // a stalled character keeps its place
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_ch_r)))
    else $error("stalled character lost");

endmodule

`default_nettype wire
